/* design/chg_pkg.sv */
// Shared request/result types and codes for the change dispenser.
package chg_pkg;

    localparam int FIELD_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Request modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_CHANGE = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DISPENSE  = 2'd0;
    localparam logic [1:0] KIND_END       = 2'd1;
    localparam logic [1:0] KIND_INVENTORY = 2'd2;

    // Register map
    localparam logic [PADDR_W-1:0] ADDR_ENTRIES = 3'd0;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         entry_index;
        logic [FIELD_W-1:0] denom_value;
        logic [FIELD_W-1:0] denom_stock;
        logic [FIELD_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] out_value;
        logic [FIELD_W-1:0] out_quantity;
        logic               last;
    } res_t;

endpackage

/* design/greedy_change_dispenser.sv */
// Greedy change dispenser: denomination table, bit-serial divide and multiply, result buffer.
//
//  Channel   Ports                             Moves
//  --------  --------------------------------  ------------------------------------
//  request   s_valid s_ready s_data            load / make change / report request
//  result    m_valid m_ready m_data            dispensed, remainder, inventory rows
//  config    psel penable pwrite paddr pwdata  entries_in_use at address 0
//
// A load writes its table entry; change and report requests walk the entries in order,
// skipping unusable ones, and a change closes with a remainder result. A divided entry
// yields one quotient bit per cycle, then is emitted; when stock runs out first,
// stock * value is subtracted by a bit-serial multiply. Reset clears both tables and entries_in_use.
// A waiting result holds in the output register; the walk stalls only when it needs
// that register while it is still full.
module greedy_change_dispenser
    import chg_pkg::*;
#(
    parameter int NUM_ENTRIES = 8,
    parameter int VALUE_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output res_t               m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH  = (NUM_ENTRIES < 8) ? NUM_ENTRIES : 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VW     = VALUE_WIDTH;
    localparam int DCNT_W = $clog2(VW + 1);
    localparam logic [3:0] DEPTH_4 = 4'(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         entries_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               is_change_reg, is_change_next;
    logic [VW-1:0]      rem_reg, rem_next;
    logic [VW-1:0]      qty_reg, qty_next;
    logic [VW-1:0]      div_p_reg, div_p_next;
    logic [VW-1:0]      div_d_reg, div_d_next;
    logic [DCNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [VW-1:0]      mul_s_reg, mul_s_next;
    logic [VW-1:0]      mul_v_reg, mul_v_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [VW-1:0]      pend_value_reg, pend_value_next;
    logic [VW-1:0]      pend_qty_reg, pend_qty_next;
    logic               m_valid_reg, m_valid_next;
    res_t               m_data_reg, m_data_next;

    logic [VW-1:0]      value_table_reg [DEPTH];
    logic [VW-1:0]      stock_table_reg [DEPTH];

    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_idx;
    logic [VW-1:0]      tbl_value;
    logic [VW-1:0]      tbl_stock;

    logic [VW-1:0]      cur_value;
    logic [VW-1:0]      cur_stock;
    logic [VW:0]        div_trial;
    logic [VW:0]        div_diff;
    logic               div_ge;
    logic               out_free;
    logic               push;
    res_t               push_data;
    logic               cfg_we;
    logic               reg_sel;
    logic [CNT_W-1:0]   walk_n;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    assign reg_sel = (paddr[PADDR_W-1:2] == ADDR_ENTRIES[PADDR_W-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {{(PDATA_W-4){1'b0}}, entries_reg} : '0;

    assign walk_n    = (entries_reg > DEPTH_4) ? CNT_W'(DEPTH) : CNT_W'(entries_reg);
    assign cur_value = value_table_reg[idx_reg[IDX_W-1:0]];
    assign cur_stock = stock_table_reg[idx_reg[IDX_W-1:0]];

    // One restoring-division step: shift in the next dividend bit, try the subtract
    assign div_trial = {div_p_reg, div_d_reg[VW-1]};
    assign div_diff  = div_trial - {1'b0, cur_value};
    assign div_ge    = (div_trial >= {1'b0, cur_value});

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        is_change_next  = is_change_reg;
        rem_next        = rem_reg;
        qty_next        = qty_reg;
        div_p_next      = div_p_reg;
        div_d_next      = div_d_reg;
        div_cnt_next    = div_cnt_reg;
        mul_s_next      = mul_s_reg;
        mul_v_next      = mul_v_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_qty_next   = pend_qty_reg;
        push            = 1'b0;
        push_data       = '0;
        tbl_we          = 1'b0;
        tbl_idx         = idx_reg[IDX_W-1:0];
        tbl_value       = cur_value;
        tbl_stock       = cur_stock;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.mode)
                        MODE_LOAD: begin
                            if ({1'b0, s_data.entry_index} < DEPTH_4) begin
                                tbl_we    = 1'b1;
                                tbl_idx   = s_data.entry_index[IDX_W-1:0];
                                tbl_value = VW'(s_data.denom_value);
                                tbl_stock = VW'(s_data.denom_stock);
                            end
                        end
                        MODE_CHANGE: begin
                            rem_next       = VW'(s_data.amount);
                            idx_next       = '0;
                            n_next         = walk_n;
                            is_change_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        MODE_REPORT: begin
                            idx_next        = '0;
                            n_next          = walk_n;
                            is_change_next  = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (idx_reg == n_reg) begin
                    if (is_change_reg) begin
                        if (out_free) begin
                            push                   = 1'b1;
                            push_data.kind         = KIND_END;
                            push_data.out_value    = '0;
                            push_data.out_quantity = FIELD_W'(rem_reg);
                            push_data.last         = 1'b1;
                            state_next             = ST_IDLE;
                        end
                    end else if (!pend_valid_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        push                   = 1'b1;
                        push_data.kind         = KIND_INVENTORY;
                        push_data.out_value    = FIELD_W'(pend_value_reg);
                        push_data.out_quantity = FIELD_W'(pend_qty_reg);
                        push_data.last         = 1'b1;
                        pend_valid_next        = 1'b0;
                        state_next             = ST_IDLE;
                    end
                end else if (is_change_reg) begin
                    if (cur_value == '0 || cur_stock == '0) begin
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        div_p_next   = '0;
                        div_d_next   = rem_reg;
                        div_cnt_next = DCNT_W'(VW);
                        state_next   = ST_DIV;
                    end
                end else if (cur_value == '0) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!pend_valid_reg || out_free) begin
                    // Hold each row back one step so the final one can carry last
                    if (pend_valid_reg) begin
                        push                   = 1'b1;
                        push_data.kind         = KIND_INVENTORY;
                        push_data.out_value    = FIELD_W'(pend_value_reg);
                        push_data.out_quantity = FIELD_W'(pend_qty_reg);
                        push_data.last         = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_value_next = cur_value;
                    pend_qty_next   = cur_stock;
                    idx_next        = idx_reg + 1'b1;
                end
            end

            ST_DIV: begin
                if (div_cnt_reg != '0) begin
                    div_p_next   = div_ge ? div_diff[VW-1:0] : div_trial[VW-1:0];
                    div_d_next   = {div_d_reg[VW-2:0], div_ge};
                    div_cnt_next = div_cnt_reg - 1'b1;
                end else if (div_d_reg == '0) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end else if (div_d_reg <= cur_stock) begin
                    qty_next   = div_d_reg;
                    rem_next   = div_p_reg;
                    tbl_we     = 1'b1;
                    tbl_stock  = cur_stock - div_d_reg;
                    state_next = ST_EMIT;
                end else begin
                    // Stock runs out first: drop stock * value from the remainder
                    qty_next   = cur_stock;
                    tbl_we     = 1'b1;
                    tbl_stock  = '0;
                    mul_s_next = cur_stock;
                    mul_v_next = cur_value;
                    state_next = ST_MUL;
                end
            end

            ST_MUL: begin
                if (mul_s_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    if (mul_s_reg[0]) begin
                        rem_next = rem_reg - mul_v_reg;
                    end
                    mul_s_next = mul_s_reg >> 1;
                    mul_v_next = mul_v_reg << 1;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    push                   = 1'b1;
                    push_data.kind         = KIND_DISPENSE;
                    push_data.out_value    = FIELD_W'(cur_value);
                    push_data.out_quantity = FIELD_W'(qty_reg);
                    push_data.last         = 1'b0;
                    idx_next               = idx_reg + 1'b1;
                    state_next             = ST_SCAN;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            entries_reg    <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            rem_reg        <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                value_table_reg[i] <= '0;
                stock_table_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            rem_reg        <= rem_next;
            if (cfg_we) begin
                entries_reg <= pwdata[3:0];
            end
            if (tbl_we) begin
                value_table_reg[tbl_idx] <= tbl_value;
                stock_table_reg[tbl_idx] <= tbl_stock;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        is_change_reg  <= is_change_next;
        qty_reg        <= qty_next;
        div_p_reg      <= div_p_next;
        div_d_reg      <= div_d_next;
        div_cnt_reg    <= div_cnt_next;
        mul_s_reg      <= mul_s_next;
        mul_v_reg      <= mul_v_next;
        pend_value_reg <= pend_value_next;
        pend_qty_reg   <= pend_qty_next;
        m_data_reg     <= m_data_next;
    end

    // The walk index never runs past the walk length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg <= n_reg))
        else $error("walk index past walk length");

    // Report rows are held back only during a report walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && state_reg != ST_IDLE) |-> !is_change_reg)
        else $error("pending inventory row during change walk");

    // The remaining amount only shrinks while a request is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> (rem_reg <= $past(rem_reg)))
        else $error("remainder grew during walk");

    // A closing remainder result always ends its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_END) |-> m_data_reg.last)
        else $error("request end without last");

endmodule
